// ----- hw/rtl/load_and_alu_execute_top_assert.svh -----
// Assertion macros for the load and ALU execute block.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef LOAD_AND_ALU_EXECUTE_TOP_ASSERT_SVH
`define LOAD_AND_ALU_EXECUTE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lae_pkg.sv -----
// Package for the load and ALU execute block: payload structs, register
// file types, opcode fields and flag positions. No dependencies.
package lae_pkg;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] hl_byte;
  } in_item_t;

  typedef struct packed {
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
    logic        hl_used;
    logic [7:0]  accumulator;
    logic [7:0]  flags;
    logic [15:0] next_pc;
  } out_item_t;

  // Eight byte registers B,C,D,E,H,L,A,F at slots 0..7.
  typedef logic [7:0][7:0] rf_t;

  // Register file update produced by one instruction.
  typedef struct packed {
    logic       dst_we;
    logic [2:0] dst_slot;
    logic [7:0] dst_data;
    logic       f_we;
    logic [7:0] f_data;
  } rf_wr_t;

  typedef enum logic [2:0] {
    AluAdd = 3'd0,
    AluAdc = 3'd1,
    AluSub = 3'd2,
    AluSbc = 3'd3,
    AluAnd = 3'd4,
    AluXor = 3'd5,
    AluOr  = 3'd6,
    AluCp  = 3'd7
  } alu_op_e;

  localparam logic [7:0] OpHalt  = 8'h76;
  localparam logic [1:0] GrpLoad = 2'b01;
  localparam logic [1:0] GrpAlu  = 2'b10;

  localparam logic [2:0] IdxMem = 3'd6;
  localparam logic [2:0] IdxA   = 3'd7;

  localparam logic [2:0] SlotH = 3'd4;
  localparam logic [2:0] SlotL = 3'd5;
  localparam logic [2:0] SlotA = 3'd6;
  localparam logic [2:0] SlotF = 3'd7;

  localparam int unsigned FlagZ = 7;
  localparam int unsigned FlagN = 6;
  localparam int unsigned FlagH = 5;
  localparam int unsigned FlagC = 4;

  // Operand index 7 names A, which lives in slot 6; 0..5 map directly.
  function automatic logic [2:0] slot_of(input logic [2:0] idx);
    logic [2:0] slot;
    slot = (idx == IdxA) ? SlotA : idx;
    return slot;
  endfunction

endpackage

// ----- hw/rtl/load_and_alu_execute_top.sv -----
// Top level of the load and ALU execute block: input register, execute
// logic, architectural state and result register. Depends on lae_pkg.
//
//   Channel | Valid       | Stall       | Payload
//   --------+-------------+-------------+--------------------------
//   input   | in_valid_i  | in_stall_o  | in_data_i  (in_item_t)
//   output  | out_valid_o | out_stall_i | out_data_o (out_item_t)
//
// One instruction per cycle unless the output stalls; each passes the input register, then the result register.
// The execute step is bounded by the single 8-bit ALU and the register file write.
// Reset clears all eight registers, the program counter and both valid flags.
// An output stall holds the result; one further instruction waits in the input stage.
module load_and_alu_execute_top import lae_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  in_item_t    in_q;
  logic        in_valid_q, in_valid_d;
  out_item_t   out_q;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        in_accept;
  rf_t         rf;
  logic [15:0] pc;
  rf_wr_t      wr;
  out_item_t   result;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  lae_decode u_decode (
    .item_i   (in_q),
    .rf_i     (rf),
    .pc_i     (pc),
    .wr_o     (wr),
    .result_o (result)
  );

  lae_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .wr_i   (wr),
    .rf_o   (rf),
    .pc_o   (pc)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "load_and_alu_execute_top_assert.svh"

  // An opcode cannot both read and write the byte at HL.
  `LAE_ASSERT_SAME(a_no_mem_rw, out_valid_q, !(out_q.mem_write && out_q.hl_used), "HL read and write")
  // The flag register never holds anything in its low nibble.
  `LAE_ASSERT_SAME(a_flags_low, out_valid_q, out_q.flags[3:0] == 4'd0, "flag low bits set")
  // Every executed instruction presents a result carrying the incremented PC.
  `LAE_ASSERT_NEXT(a_pc_step, advance, out_valid_q && out_q.next_pc == $past(pc) + 16'd1, "PC step")
  // A stalled input stage must not lose its instruction.
  `LAE_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(in_q), "input stage lost")

endmodule

// ----- hw/rtl/lae_alu.sv -----
// Eight-bit ALU for ADD, ADC, SUB, SBC, AND, XOR, OR and CP with Z/N/H/C.
// Depends on lae_pkg.
module lae_alu import lae_pkg::*; (
  input  alu_op_e    op_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic       cin_i,
  output logic [7:0] res_o,
  output logic [7:0] flags_o
);

  logic       c_use;
  logic [8:0] sum9;
  logic [4:0] half5;
  logic [8:0] sub_rhs;
  logic [4:0] sub_rhs_lo;
  logic       f_n, f_h, f_c;

  always_comb begin
    c_use      = ((op_i == AluAdc) || (op_i == AluSbc)) ? cin_i : 1'b0;
    sum9       = {1'b0, a_i} + {1'b0, b_i} + {8'd0, c_use};
    half5      = {1'b0, a_i[3:0]} + {1'b0, b_i[3:0]} + {4'd0, c_use};
    sub_rhs    = {1'b0, b_i} + {8'd0, c_use};
    sub_rhs_lo = {1'b0, b_i[3:0]} + {4'd0, c_use};
    res_o      = 8'd0;
    f_n        = 1'b0;
    f_h        = 1'b0;
    f_c        = 1'b0;
    unique case (op_i) inside
      AluAdd, AluAdc: begin
        res_o = sum9[7:0];
        f_h   = half5[4];
        f_c   = sum9[8];
      end
      AluSub, AluSbc, AluCp: begin
        res_o = a_i - b_i - {7'd0, c_use};
        f_n   = 1'b1;
        f_h   = {1'b0, a_i[3:0]} < sub_rhs_lo;
        f_c   = {1'b0, a_i} < sub_rhs;
      end
      AluAnd: begin
        res_o = a_i & b_i;
        f_h   = 1'b1;
      end
      AluXor: res_o = a_i ^ b_i;
      AluOr:  res_o = a_i | b_i;
      default: res_o = 8'd0;
    endcase
    flags_o        = 8'd0;
    flags_o[FlagZ] = (res_o == 8'd0);
    flags_o[FlagN] = f_n;
    flags_o[FlagH] = f_h;
    flags_o[FlagC] = f_c;
  end

endmodule

// ----- hw/rtl/lae_decode.sv -----
// Instruction decode and execute: operand selection, load and ALU groups,
// register file update and result fields. Depends on lae_pkg and lae_alu.
module lae_decode import lae_pkg::*; (
  input  in_item_t    item_i,
  input  rf_t         rf_i,
  input  logic [15:0] pc_i,
  output rf_wr_t      wr_o,
  output out_item_t   result_o
);

  logic [1:0]  grp;
  logic [2:0]  src;
  logic [2:0]  dst;
  logic        is_load;
  logic        is_alu;
  logic        src_mem;
  logic [7:0]  val;
  logic [15:0] hl;
  logic [7:0]  alu_res;
  logic [7:0]  alu_flags;
  logic        mem_wr;
  alu_op_e     alu_op;

  assign grp     = item_i.opcode[7:6];
  assign src     = item_i.opcode[2:0];
  assign dst     = item_i.opcode[5:3];
  assign alu_op  = alu_op_e'(dst);
  assign is_load = (grp == GrpLoad) && (item_i.opcode != OpHalt);
  assign is_alu  = (grp == GrpAlu);
  assign src_mem = (src == IdxMem);
  assign hl      = {rf_i[SlotH], rf_i[SlotL]};
  assign val     = src_mem ? item_i.hl_byte : rf_i[slot_of(src)];
  assign mem_wr  = is_load && (dst == IdxMem);

  lae_alu u_alu (
    .op_i    (alu_op),
    .a_i     (rf_i[SlotA]),
    .b_i     (val),
    .cin_i   (rf_i[SlotF][FlagC]),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  always_comb begin
    wr_o = '0;
    if (is_load && !mem_wr) begin
      wr_o.dst_we   = 1'b1;
      wr_o.dst_slot = slot_of(dst);
      wr_o.dst_data = val;
    end else if (is_alu) begin
      // Compare only sets the flags; A is kept.
      wr_o.dst_we   = (alu_op != AluCp);
      wr_o.dst_slot = SlotA;
      wr_o.dst_data = alu_res;
      wr_o.f_we     = 1'b1;
      wr_o.f_data   = alu_flags;
    end
  end

  always_comb begin
    result_o           = '0;
    result_o.mem_write = mem_wr;
    result_o.hl_used   = (is_load || is_alu) && src_mem;
    result_o.mem_addr  = (mem_wr || result_o.hl_used) ? hl : 16'd0;
    result_o.mem_data  = mem_wr ? val : 8'd0;
    result_o.accumulator =
      (wr_o.dst_we && (wr_o.dst_slot == SlotA)) ? wr_o.dst_data : rf_i[SlotA];
    result_o.flags = (wr_o.f_we ? wr_o.f_data : rf_i[SlotF]) & 8'hF0;
    result_o.next_pc = pc_i + 16'd1;
  end

endmodule

// ----- hw/rtl/lae_regs.sv -----
// Architectural state: the eight byte registers and the program counter.
// Depends on lae_pkg.
module lae_regs import lae_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  rf_wr_t      wr_i,
  output rf_t         rf_o,
  output logic [15:0] pc_o
);

  rf_t         rf_q, rf_d;
  logic [15:0] pc_q, pc_d;

  always_comb begin
    rf_d = rf_q;
    pc_d = pc_q;
    if (en_i) begin
      pc_d = pc_q + 16'd1;
      if (wr_i.f_we) begin
        rf_d[SlotF] = wr_i.f_data;
      end
      if (wr_i.dst_we) begin
        rf_d[wr_i.dst_slot] = wr_i.dst_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q <= '0;
      pc_q <= '0;
    end else begin
      rf_q <= rf_d;
      pc_q <= pc_d;
    end
  end

  assign rf_o = rf_q;
  assign pc_o = pc_q;

endmodule

// ----- dv/load_and_alu_execute_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for load_and_alu_execute_top: randomised loads and ALU
// operations with a built-in predictor of registers, flags and PC. Needs lae_pkg.
module load_and_alu_execute_top_tb;
  import lae_pkg::*;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned RandomOps  = 1725;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  load_and_alu_execute_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Architectural state as the predictor sees it.
  rf_t         arch_rf = '0;
  logic [15:0] arch_pc = '0;

  in_item_t    insn_q[$];
  out_item_t   result_q[$];
  bit          no_idle  = 1'b0;
  int unsigned bad_cnt  = 0;
  int unsigned cyc_cnt  = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;

  // Operand index 7 is A, which sits in slot 6 of the register file.
  function automatic logic [2:0] reg_slot(input logic [2:0] idx);
    return (idx == IdxA) ? SlotA : idx;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Executes one instruction on the shadow state and returns the expected result.
  function automatic out_item_t exec_insn(input in_item_t it);
    out_item_t   r;
    logic [2:0]  s_idx;
    logic [2:0]  d_idx;
    logic [15:0] hl;
    logic [7:0]  val;
    logic [7:0]  a;
    logic [7:0]  res;
    logic [7:0]  f;
    logic [8:0]  sum;
    logic [4:0]  half;
    logic        c;
    logic        keep_a;
    alu_op_e     op_k;
    r      = '0;
    hl     = {arch_rf[SlotH], arch_rf[SlotL]};
    s_idx  = it.opcode[2:0];
    d_idx  = it.opcode[5:3];
    if ((it.opcode[7:6] == GrpLoad && it.opcode != OpHalt) || it.opcode[7:6] == GrpAlu) begin
      if (s_idx == IdxMem) begin
        val        = it.hl_byte;
        r.hl_used  = 1'b1;
        r.mem_addr = hl;
      end else begin
        val = arch_rf[reg_slot(s_idx)];
      end
      if (it.opcode[7:6] == GrpLoad) begin
        if (d_idx == IdxMem) begin
          r.mem_write = 1'b1;
          r.mem_addr  = hl;
          r.mem_data  = val;
        end else begin
          arch_rf[reg_slot(d_idx)] = val;
        end
      end else begin
        a      = arch_rf[SlotA];
        f      = '0;
        keep_a = 1'b0;
        op_k   = alu_op_e'(d_idx);
        case (op_k)
          AluAdd, AluAdc: begin
            c        = (op_k == AluAdc) ? arch_rf[SlotF][FlagC] : 1'b0;
            sum      = {1'b0, a} + {1'b0, val} + c;
            half     = {1'b0, a[3:0]} + {1'b0, val[3:0]} + c;
            f[FlagH] = half[4];
            f[FlagC] = sum[8];
            res      = sum[7:0];
          end
          AluSub, AluSbc, AluCp: begin
            c        = (op_k == AluSbc) ? arch_rf[SlotF][FlagC] : 1'b0;
            f[FlagN] = 1'b1;
            f[FlagH] = ({1'b0, a[3:0]} < ({1'b0, val[3:0]} + c));
            f[FlagC] = ({1'b0, a} < ({1'b0, val} + c));
            res      = a - val - c;
            keep_a   = (op_k == AluCp);
          end
          AluAnd: begin
            res      = a & val;
            f[FlagH] = 1'b1;
          end
          AluXor: res = a ^ val;
          default: res = a | val;
        endcase
        f[FlagZ]       = (res == 8'h00);
        arch_rf[SlotF] = f;
        if (!keep_a) arch_rf[SlotA] = res;
      end
    end
    arch_pc       = arch_pc + 16'd1;
    r.accumulator = arch_rf[SlotA];
    r.flags       = arch_rf[SlotF] & 8'hF0;
    r.next_pc     = arch_pc;
    return r;
  endfunction

  // Instruction driver: a transfer on the input channel records its expected result.
  always @(posedge clk_i or negedge rst_ni) begin
    logic        take;
    int unsigned gap_n;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      take = in_valid_i && !in_stall_o;
      if (take) result_q.push_back(exec_insn(in_data_i));
      if (!in_valid_i || take) begin
        gap_n = take ? (no_idle ? 0 : idle_len()) : gap_left;
        if (gap_n == 0 && insn_q.size() > 0) begin
          in_data_i  <= insn_q.pop_front();
          in_valid_i <= 1'b1;
          gap_left   <= 0;
        end else begin
          in_valid_i <= 1'b0;
          gap_left   <= (gap_n > 0) ? gap_n - 1 : 0;
        end
      end
    end
  end

  // Result monitor and output stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t   exp_r;
    int unsigned n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("%0t: unexpected result wr=%0b addr=%h data=%h used=%0b a=%h f=%h pc=%h",
                     $realtime, out_data_o.mem_write, out_data_o.mem_addr, out_data_o.mem_data,
                     out_data_o.hl_used, out_data_o.accumulator, out_data_o.flags,
                     out_data_o.next_pc);
        end else begin
          exp_r = result_q.pop_front();
          if (out_data_o !== exp_r) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("%0t: expected wr=%0b addr=%h data=%h used=%0b a=%h f=%h pc=%h",
                       $realtime, exp_r.mem_write, exp_r.mem_addr, exp_r.mem_data,
                       exp_r.hl_used, exp_r.accumulator, exp_r.flags, exp_r.next_pc);
              $display("%0t: actual   wr=%0b addr=%h data=%h used=%0b a=%h f=%h pc=%h",
                       $realtime, out_data_o.mem_write, out_data_o.mem_addr,
                       out_data_o.mem_data, out_data_o.hl_used, out_data_o.accumulator,
                       out_data_o.flags, out_data_o.next_pc);
            end
          end
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else begin
        n = no_idle ? 0 : idle_len();
        out_stall_i <= (n > 0);
        hold_left   <= (n > 0) ? n - 1 : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt == CycleLimit) begin
      $display("load_and_alu_execute_top_tb: errors");
      $finish;
    end
  end

  initial begin
    in_item_t    it;
    int unsigned pick;
    int unsigned done_ops;
    int unsigned chunk;
    logic [7:0]  dir_ops[$];
    logic [7:0]  dir_hl[$];
    // Directed part: no-ops, halt, loads through HL including writes to H and L,
    // every ALU operation from memory, carry into ADC/SBC, and CP keeping A.
    dir_ops = '{8'h00, 8'hFF, 8'h76, 8'h7E, 8'h66, 8'h6E, 8'h77, 8'h47, 8'h86, 8'h86,
                8'h8E, 8'h96, 8'h9E, 8'hA6, 8'h7E, 8'hAE, 8'hB6, 8'hBE, 8'hBF, 8'hAF,
                8'h80, 8'h70, 8'h60, 8'h88, 8'h98};
    dir_hl  = '{8'hFF, 8'h00, 8'hAA, 8'h0F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01, 8'hF0,
                8'hFF, 8'h01, 8'hFF, 8'h00, 8'h5A, 8'hFF, 8'h00, 8'hA5, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_ops[i]) insn_q.push_back('{opcode: dir_ops[i], hl_byte: dir_hl[i]});
    while (insn_q.size() > 0) @(posedge clk_i);

    done_ops = 0;
    chunk    = 0;
    while (done_ops < RandomOps) begin
      no_idle = (chunk % 4 == 3);
      repeat (250) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      it.opcode = 8'h80 | 8'($urandom_range(0, 63));
        else if (pick < 80) it.opcode = 8'h40 | 8'($urandom_range(0, 63));
        else if (pick < 90)
          it.opcode = 8'($urandom_range(0, 63)) | ($urandom_range(0, 1) ? 8'hC0 : 8'h00);
        else                it.opcode = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 15)      it.hl_byte = 8'h00;
        else if (pick < 30) it.hl_byte = 8'hFF;
        else                it.hl_byte = 8'($urandom_range(0, 255));
        insn_q.push_back(it);
        done_ops++;
      end
      while (insn_q.size() > 0) @(posedge clk_i);
      chunk++;
    end
    no_idle = 1'b0;

    while (insn_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bad_cnt == 0) begin
      $display("load_and_alu_execute_top_tb: clean");
    end else begin
      $display("load_and_alu_execute_top_tb: errors");
    end
    $finish;
  end

endmodule
